// ----- design/tpr_pkg.sv -----
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types and constants for the telemetry poll responder.
// ----------------------------------------------------------------------------
package tpr_pkg;

	localparam logic [7:0] START_BYTE  = 8'h7E;
	localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
	localparam logic [7:0] ESCAPE_XOR  = 8'h20;
	localparam logic [7:0] FRAME_HEAD  = 8'h10;
	localparam logic [7:0] CSUM_BASE   = 8'hFF;

	// Input word kinds carried on tuser
	localparam logic CMD_RX_BYTE = 1'b0;
	localparam logic CMD_LOAD    = 1'b1;

	// Index of the checksum byte within the frame
	localparam logic [2:0] LAST_IDX = 3'd7;

	// Frame job handed from the front to the back through the queue
	typedef struct packed {
		logic [15:0] data_id;
		logic [31:0] data_value;
	} frame_job_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} back_state_t;

endpackage

// ----- design/telemetry_poll_responder.sv -----
// ----------------------------------------------------------------------------
// A polling word is queued; the back sequencer then leaves idle and loads the
// first reply byte into its output register. Throughput: one input word per
// cycle while the 2-deep job queue has room; a reply is 8 to 15 bytes (stuffing
// adds up to 7), and the back sequencer passes through idle between frames.
// Reset: arst_n clears sensor id, poll history, frame store, queue and output.
// ----------------------------------------------------------------------------
// telemetry_poll_responder
// Polled telemetry bus responder: the front classifies loads and polls, the
// back sends the stuffed 8-byte reply frame.
// ----------------------------------------------------------------------------
module telemetry_poll_responder import tpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sensor_id_we,
	input  logic [7:0]  sensor_id_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // rx_byte[7:0], data_id[23:8], data_value[55:24]
	input  logic        s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
	output logic        m_axis_tlast
);

	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_valid;
	frame_job_t q_in_job;
	frame_job_t q_head_job;

	tpr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.sensor_id_we    (sensor_id_we),
		.sensor_id_wdata (sensor_id_wdata),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_command      (s_axis_tuser),
		.in_rx_byte      (s_axis_tdata[7:0]),
		.in_data_id      (s_axis_tdata[23:8]),
		.in_data_value   (s_axis_tdata[55:24]),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_job           (q_in_job)
	);

	tpr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_in_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (q_head_job)
	);

	tpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (q_head_job),
		.job_pop   (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ----- design/tpr_front.sv -----
// ----------------------------------------------------------------------------
// tpr_front
// Accepts input words, holds the loaded frame and the poll history, and
// queues a frame job when this sensor is polled.
// ----------------------------------------------------------------------------
module tpr_front import tpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sensor_id_we,
	input  logic [7:0]  sensor_id_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_command,
	input  logic [7:0]  in_rx_byte,
	input  logic [15:0] in_data_id,
	input  logic [31:0] in_data_value,
	input  logic        q_full,
	output logic        q_push,
	output frame_job_t  q_job
);

	logic [7:0]  sensor_id_q;
	logic [7:0]  prev_byte_q;
	logic [15:0] stored_id_q;
	logic [31:0] stored_value_q;
	logic        loaded_q;
	logic        accept;
	logic        poll_hit;

	// Stall only when no queue slot is left
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify a received byte as a poll for this sensor
	assign poll_hit = (in_command == CMD_RX_BYTE) && (prev_byte_q == START_BYTE) &&
		(in_rx_byte == sensor_id_q) && loaded_q;

	assign q_push             = accept && poll_hit;
	assign q_job.data_id      = stored_id_q;
	assign q_job.data_value   = stored_value_q;

	// Hold the configured sensor id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_id_q <= 8'h00;
		end else if (sensor_id_we) begin
			sensor_id_q <= sensor_id_wdata;
		end
	end

	// Update the frame store and the poll history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_byte_q    <= 8'h00;
			stored_id_q    <= 16'h0000;
			stored_value_q <= 32'h0000_0000;
			loaded_q       <= 1'b0;
		end else if (accept) begin
			if (in_command == CMD_LOAD) begin
				stored_id_q    <= in_data_id;
				stored_value_q <= in_data_value;
				loaded_q       <= 1'b1;
			end else begin
				prev_byte_q <= in_rx_byte;
				if (poll_hit) begin
					loaded_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- design/tpr_fifo.sv -----
// ----------------------------------------------------------------------------
// tpr_fifo
// Two-entry queue of frame jobs between the front and the back.
// ----------------------------------------------------------------------------
module tpr_fifo import tpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_job_t push_job,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output frame_job_t head_job
);

	frame_job_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_job   = entry_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- design/tpr_back.sv -----
// ----------------------------------------------------------------------------
// tpr_back
// Serializes one queued frame job into stuffed bus bytes with the running
// end-around-carry checksum, one byte per cycle into a free output register.
// ----------------------------------------------------------------------------
module tpr_back import tpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  frame_job_t job,
	output logic       job_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	back_state_t state_q;
	back_state_t state_d;
	logic [2:0]  idx_q;
	logic        esc_q;
	logic [7:0]  sum_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        slot_free;
	logic [7:0]  cur_byte;
	logic        needs_esc;
	logic        emit;
	logic        advance;
	logic        set_esc;
	logic [7:0]  emit_byte;
	logic        emit_last;
	logic [8:0]  sum_raw;
	logic [8:0]  sum_wrap;

	assign slot_free = !out_valid_q || out_ready;

	// Pick the current frame byte
	always_comb begin
		unique case (idx_q)
			3'd0:    cur_byte = FRAME_HEAD;
			3'd1:    cur_byte = job.data_id[7:0];
			3'd2:    cur_byte = job.data_id[15:8];
			3'd3:    cur_byte = job.data_value[7:0];
			3'd4:    cur_byte = job.data_value[15:8];
			3'd5:    cur_byte = job.data_value[23:16];
			3'd6:    cur_byte = job.data_value[31:24];
			default: cur_byte = CSUM_BASE - sum_q;
		endcase
	end

	assign needs_esc = (idx_q != 3'd0) &&
		((cur_byte == START_BYTE) || (cur_byte == ESCAPE_BYTE));

	// Fold the next byte into the checksum with end-around carry
	assign sum_raw  = {1'b0, sum_q} + {1'b0, cur_byte};
	assign sum_wrap = sum_raw + {8'h00, sum_raw[8]};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (advance && (idx_q == LAST_IDX)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Byte selection and control outputs
	always_comb begin
		emit      = 1'b0;
		advance   = 1'b0;
		set_esc   = 1'b0;
		emit_byte = cur_byte;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_SEND: begin
				if (slot_free) begin
					emit = 1'b1;
					if (esc_q) begin
						emit_byte = cur_byte ^ ESCAPE_XOR;
						emit_last = (idx_q == LAST_IDX);
						advance   = 1'b1;
					end else if (needs_esc) begin
						emit_byte = ESCAPE_BYTE;
						set_esc   = 1'b1;
					end else begin
						emit_last = (idx_q == LAST_IDX);
						advance   = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign job_pop = advance && (idx_q == LAST_IDX);

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 3'd0;
			esc_q   <= 1'b0;
			sum_q   <= 8'h00;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				idx_q <= 3'd0;
				esc_q <= 1'b0;
				sum_q <= 8'h00;
			end else if (advance) begin
				idx_q <= idx_q + 3'd1;
				esc_q <= 1'b0;
				if (idx_q != LAST_IDX) begin
					sum_q <= sum_wrap[7:0];
				end
			end else if (set_esc) begin
				esc_q <= 1'b1;
			end
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// The last byte of a frame returns the sequencer to idle
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == ST_IDLE))
		else $error("frame end byte did not finish the frame");

	// An escape is pending only while a frame is being sent
	a_esc_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> (state_q == ST_SEND))
		else $error("escape pending outside of a frame");

	// A job is popped only when one is queued
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("frame job popped from an empty queue");

	// An idle sequencer always restarts at the frame head
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == ST_IDLE) |-> ((idx_q == 3'd0) && !esc_q && (sum_q == 8'h00)))
		else $error("frame started from a dirty sequencer");

endmodule

// ----- sim/tb_telemetry_poll_responder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_telemetry_poll_responder
// Self-checking bench for the telemetry poll responder. A queue of bus words
// (loads and received bytes) feeds a bursty stream driver. Each accepted word
// runs through a local frame predictor that builds the stuffed reply bytes.
// A monitor behind a stalling receiver checks every reply byte against them.
// The run steps through several sensor id settings between drained phases.
// ----------------------------------------------------------------------------
module tb_telemetry_poll_responder import tpr_pkg::*; ();

	localparam int ITEMS_PER_PHASE = 75;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic        cmd;
		logic [7:0]  rx;
		logic [15:0] id;
		logic [31:0] val;
	} bus_word_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} tx_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sensor_id_we = 1'b0;
	logic [7:0]  sensor_id_wdata = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;   // rx_byte[7:0], data_id[23:8], data_value[55:24]
	logic        s_axis_tuser = CMD_RX_BYTE;   // command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;   // tx_byte[7:0]
	logic        m_axis_tlast;

	// Words waiting to be sent and reply bytes waiting to arrive
	bus_word_t pending_words[$];
	tx_word_t  reply_bytes[$];

	// Predictor state
	logic [7:0]  poll_id = 8'h00;
	logic [7:0]  prev_rx = 8'h00;
	logic [15:0] held_id = 16'h0000;
	logic [31:0] held_value = 32'h0;
	logic        frame_armed = 1'b0;

	int err_count = 0;
	int hold_requests = 0;

	telemetry_poll_responder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sensor_id_we   (sensor_id_we),
		.sensor_id_wdata(sensor_id_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Append one reply byte, escaping start and escape bytes when it is stuffable
	task automatic push_tx_byte(input logic [7:0] b, input logic last, input logic stuffable);
		tx_word_t w;
		if (stuffable && (b == START_BYTE || b == ESCAPE_BYTE)) begin
			w.data = ESCAPE_BYTE;
			w.last = 1'b0;
			reply_bytes.push_back(w);
			w.data = b ^ ESCAPE_XOR;
		end else begin
			w.data = b;
		end
		w.last = last;
		reply_bytes.push_back(w);
	endtask

	// Update the responder state for one word and queue the reply it causes
	task automatic model_bus_word(input bus_word_t w);
		logic [7:0]  body [0:6];
		logic [15:0] sum;
		if (w.cmd == CMD_LOAD) begin
			held_id = w.id;
			held_value = w.val;
			frame_armed = 1'b1;
		end else begin
			if (prev_rx == START_BYTE && w.rx == poll_id && frame_armed) begin
				body[0] = FRAME_HEAD;
				body[1] = held_id[7:0];
				body[2] = held_id[15:8];
				body[3] = held_value[7:0];
				body[4] = held_value[15:8];
				body[5] = held_value[23:16];
				body[6] = held_value[31:24];
				sum = {8'h00, FRAME_HEAD};
				push_tx_byte(body[0], 1'b0, 1'b0);
				for (int i = 1; i < 7; i++) begin
					sum = sum + body[i];
					sum = sum + (sum >> 8);
					sum = sum & 16'h00FF;
					push_tx_byte(body[i], 1'b0, 1'b1);
				end
				push_tx_byte(CSUM_BASE - sum[7:0], 1'b1, 1'b1);
				frame_armed = 1'b0;
			end
			prev_rx = w.rx;
		end
	endtask

	// Stream driver: bursts of words with random gaps
	int burst_left = 0;
	int gap_left = 0;
	bus_word_t drv_word;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				model_bus_word(drv_word);
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the offered word
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				drv_word = pending_words.pop_front();
				s_axis_tdata <= {drv_word.val, drv_word.id, drv_word.rx};
				s_axis_tuser <= drv_word.cmd;
				s_axis_tvalid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern per segment, plus a long hold on request
	int seg_left = 0;
	int seg_mode = 0;
	int seg_phase = 0;
	int hold_left = 0;
	int hold_seen = 0;

	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 200);
				seg_mode = $urandom_range(0, 3);
			end
			seg_left--;
			seg_phase++;
			case (seg_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= (seg_phase % 4) != 0;
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Compare each reply byte with the oldest prediction
	always @(posedge clk) begin
		tx_word_t exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (reply_bytes.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("unexpected reply byte %02h last %0b", m_axis_tdata, m_axis_tlast);
			end else begin
				exp_w = reply_bytes.pop_front();
				if (m_axis_tdata !== exp_w.data || m_axis_tlast !== exp_w.last) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("reply mismatch: expected %02h last %0b, got %02h last %0b",
							exp_w.data, exp_w.last, m_axis_tdata, m_axis_tlast);
				end
			end
		end
	end

	// Stimulus helpers
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? START_BYTE : ESCAPE_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_rx(input logic [7:0] b);
		bus_word_t w;
		w.cmd = CMD_RX_BYTE;
		w.rx = b;
		w.id = 16'($urandom);
		w.val = $urandom;
		pending_words.push_back(w);
	endtask

	task automatic add_load(input logic [15:0] id, input logic [31:0] val);
		bus_word_t w;
		w.cmd = CMD_LOAD;
		w.rx = 8'($urandom);
		w.id = id;
		w.val = val;
		pending_words.push_back(w);
	endtask

	// Mostly load-and-poll sequences, the rest noise bytes, lone loads and other polls
	task automatic add_traffic(input int count);
		int sel;
		logic [7:0] other;
		while (count > 0) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				add_load({pick_byte(), pick_byte()},
					{pick_byte(), pick_byte(), pick_byte(), pick_byte()});
				add_rx(START_BYTE);
				add_rx(poll_id);
				count -= 3;
			end else if (sel < 70) begin
				other = poll_id ^ (8'h01 << $urandom_range(0, 7));
				add_rx(START_BYTE);
				add_rx(other);
				count -= 2;
			end else if (sel < 80) begin
				add_rx(pick_byte());
				count--;
			end else if (sel < 88) begin
				add_load(16'($urandom), $urandom);
				count--;
			end else begin
				add_rx(START_BYTE);
				add_rx(poll_id);
				count -= 2;
			end
		end
	endtask

	// Wait until nothing is in flight, sampled away from the active edge
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_words.size() != 0 || s_axis_tvalid || reply_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_poll_id(input logic [7:0] v);
		@(posedge clk);
		sensor_id_we <= 1'b1;
		sensor_id_wdata <= v;
		@(posedge clk);
		sensor_id_we <= 1'b0;
		poll_id = v;
		@(negedge clk);
	endtask

	// Run limit
	initial begin
		#5ms;
		$display("tb_telemetry_poll_responder: done, errors");
		$finish;
	end

	// Main sequence
	initial begin
		logic [7:0] id_plan [0:5];
		id_plan[0] = 8'hFF;
		id_plan[1] = START_BYTE;
		id_plan[2] = 8'h00;
		id_plan[3] = 8'($urandom_range(0, 255));
		id_plan[4] = ESCAPE_BYTE;
		id_plan[5] = 8'($urandom_range(0, 255));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset sensor id of zero
		add_rx(START_BYTE);                  // poll with nothing loaded
		add_rx(8'h00);
		add_load(16'h0000, 32'h0000_0000);   // all-zero frame
		add_rx(START_BYTE);
		add_rx(8'h00);
		add_load(16'hFFFF, 32'hFFFF_FFFF);   // all-ones frame
		add_rx(START_BYTE);
		add_rx(8'h01);                       // poll for another id
		add_rx(START_BYTE);
		add_rx(8'h00);
		add_load(16'h7E7D, 32'h7D7E_7E7D);   // every payload byte escaped
		add_load(16'h0071, 32'h0000_0000);   // overwrite; checksum is a start byte
		add_rx(START_BYTE);
		add_load(16'h0072, 32'h0000_0000);   // load between start and poll; checksum escaped
		add_rx(8'h00);
		add_rx(8'h00);                       // poll byte without start byte
		add_rx(START_BYTE);
		add_rx(8'h00);                       // poll after the frame was sent
		wait_drained();

		// Random phases over several sensor ids
		for (int p = 0; p < 6; p++) begin
			write_poll_id(id_plan[p]);
			if (p == 3)
				hold_requests++;
			add_traffic(ITEMS_PER_PHASE);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (reply_bytes.size() != 0)
			err_count++;
		if (err_count == 0)
			$display("tb_telemetry_poll_responder: done, clean");
		else
			$display("tb_telemetry_poll_responder: done, errors");
		$finish;
	end

endmodule
